/* rtl/core/utf8sd_pkg.sv */
// Package: beat types, result codes and queue entry codes for the UTF-8 decoder.
`timescale 1ns / 1ps

package utf8sd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [20:0] code_point;
		logic [31:0] error_offset;
		logic        string_done;
	} out_beat_t;

	localparam logic [1:0] STATUS_CHAR = 2'd0;
	localparam logic [1:0] STATUS_END  = 2'd1;
	localparam logic [1:0] STATUS_ERR  = 2'd2;

	// what a queued job asks the back end to emit
	localparam logic [1:0] KIND_CHAR     = 2'd0;
	localparam logic [1:0] KIND_END      = 2'd1;
	localparam logic [1:0] KIND_ERR      = 2'd2;
	localparam logic [1:0] KIND_CHAR_END = 2'd3;

	localparam int KIND_W  = 2;
	localparam int CP_W    = 21;
	localparam int QDEPTH  = 4;

	// Table 3-7 byte bounds
	localparam logic [7:0] CONT_LO    = 8'h80;
	localparam logic [7:0] CONT_HI    = 8'hBF;
	localparam logic [7:0] LEAD2_LO   = 8'hC2;
	localparam logic [7:0] LEAD2_HI   = 8'hDF;
	localparam logic [7:0] LEAD3_LO   = 8'hE0;
	localparam logic [7:0] LEAD3_HI   = 8'hEF;
	localparam logic [7:0] LEAD_E0    = 8'hE0;
	localparam logic [7:0] E0_SEC_LO  = 8'hA0;
	localparam logic [7:0] LEAD_ED    = 8'hED;
	localparam logic [7:0] ED_SEC_HI  = 8'h9F;
	localparam logic [7:0] LEAD4_LO   = 8'hF0;
	localparam logic [7:0] LEAD4_HI   = 8'hF4;
	localparam logic [7:0] LEAD_F0    = 8'hF0;
	localparam logic [7:0] F0_SEC_LO  = 8'h90;
	localparam logic [7:0] LEAD_F4    = 8'hF4;
	localparam logic [7:0] F4_SEC_HI  = 8'h8F;
	localparam logic [7:0] ASCII_LIM  = 8'h80;

endpackage

/* rtl/core/utf8sd_front.sv */
// Front end: per-byte validation state machine, emits one queue job per result-bearing byte.
`timescale 1ns / 1ps

module utf8sd_front #(
	parameter int OFFSET_WIDTH = 32,
	parameter int ENTRY_W      = utf8sd_pkg::KIND_W + utf8sd_pkg::CP_W + OFFSET_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  utf8sd_pkg::in_beat_t  beat,
	output logic                  push,
	output logic [ENTRY_W-1:0]    entry
);

	logic [OFFSET_WIDTH-1:0] pos_q, start_q, n_pos, n_start;
	logic [20:0]             partial_q, n_partial;
	logic [1:0]              left_q, n_left;
	logic [7:0]              lo_q, hi_q, n_lo, n_hi;
	logic                    second_q, skip_q, n_second, n_skip;

	logic [7:0]  b;
	logic        eos, err, emit_char, job;
	logic [7:0]  lo, hi;
	logic [20:0] cp;
	logic [1:0]  kind;

	assign b   = beat.data_byte;
	assign eos = beat.end_of_string;

	always_comb begin
		n_pos     = pos_q;
		n_start   = start_q;
		n_partial = partial_q;
		n_left    = left_q;
		n_lo      = lo_q;
		n_hi      = hi_q;
		n_second  = second_q;
		n_skip    = skip_q;
		err       = 1'b0;
		emit_char = 1'b0;
		job       = 1'b0;
		cp        = '0;
		kind      = utf8sd_pkg::KIND_END;
		lo        = second_q ? lo_q : utf8sd_pkg::CONT_LO;
		hi        = second_q ? hi_q : utf8sd_pkg::CONT_HI;

		if (skip_q) begin
			if (eos) begin
				n_skip    = 1'b0;
				n_pos     = '0;
				n_partial = '0;
				n_left    = '0;
				n_lo      = utf8sd_pkg::CONT_LO;
				n_hi      = utf8sd_pkg::CONT_HI;
				n_second  = 1'b0;
			end else begin
				n_pos = pos_q + 1'b1;
			end
		end else begin
			if (left_q == 2'd0) begin
				n_start = pos_q;
				n_lo    = utf8sd_pkg::CONT_LO;
				n_hi    = utf8sd_pkg::CONT_HI;
				if (b < utf8sd_pkg::ASCII_LIM) begin
					emit_char = 1'b1;
					cp        = {13'd0, b};
				end else if (b >= utf8sd_pkg::LEAD2_LO && b <= utf8sd_pkg::LEAD2_HI) begin
					n_left    = 2'd1;
					n_partial = {16'd0, b[4:0]};
				end else if (b >= utf8sd_pkg::LEAD3_LO && b <= utf8sd_pkg::LEAD3_HI) begin
					n_left    = 2'd2;
					n_partial = {17'd0, b[3:0]};
					if (b == utf8sd_pkg::LEAD_E0) n_lo = utf8sd_pkg::E0_SEC_LO;
					if (b == utf8sd_pkg::LEAD_ED) n_hi = utf8sd_pkg::ED_SEC_HI;
				end else if (b >= utf8sd_pkg::LEAD4_LO && b <= utf8sd_pkg::LEAD4_HI) begin
					n_left    = 2'd3;
					n_partial = {18'd0, b[2:0]};
					if (b == utf8sd_pkg::LEAD_F0) n_lo = utf8sd_pkg::F0_SEC_LO;
					if (b == utf8sd_pkg::LEAD_F4) n_hi = utf8sd_pkg::F4_SEC_HI;
				end else begin
					err = 1'b1;
				end
				n_second = (n_left != 2'd0);
			end else begin
				if (b < lo || b > hi) begin
					err = 1'b1;
				end else begin
					n_partial = {partial_q[14:0], b[5:0]};
					n_left    = left_q - 2'd1;
					n_second  = 1'b0;
					if (n_left == 2'd0) begin
						emit_char = 1'b1;
						cp        = n_partial;
						n_partial = '0;
					end
				end
			end

			// string ends with a sequence still open
			if (!err && eos && n_left != 2'd0) err = 1'b1;

			if (err || eos) begin
				n_partial = '0;
				n_left    = '0;
				n_lo      = utf8sd_pkg::CONT_LO;
				n_hi      = utf8sd_pkg::CONT_HI;
				n_second  = 1'b0;
			end

			if (err) begin
				job  = 1'b1;
				kind = utf8sd_pkg::KIND_ERR;
				cp   = '0;
				if (eos) begin
					n_pos = '0;
				end else begin
					n_skip = 1'b1;
					n_pos  = pos_q + 1'b1;
				end
			end else if (eos) begin
				job   = 1'b1;
				kind  = emit_char ? utf8sd_pkg::KIND_CHAR_END : utf8sd_pkg::KIND_END;
				n_pos = '0;
			end else begin
				job   = emit_char;
				kind  = utf8sd_pkg::KIND_CHAR;
				n_pos = pos_q + 1'b1;
			end
		end
	end

	assign push  = accept && job;
	assign entry = {kind, cp, n_start};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			start_q   <= '0;
			partial_q <= '0;
			left_q    <= '0;
			lo_q      <= utf8sd_pkg::CONT_LO;
			hi_q      <= utf8sd_pkg::CONT_HI;
			second_q  <= 1'b0;
			skip_q    <= 1'b0;
		end else if (accept) begin
			pos_q     <= n_pos;
			start_q   <= n_start;
			partial_q <= n_partial;
			left_q    <= n_left;
			lo_q      <= n_lo;
			hi_q      <= n_hi;
			second_q  <= n_second;
			skip_q    <= n_skip;
		end
	end

endmodule

/* rtl/core/utf8sd_fifo.sv */
// Small register queue between the front and back ends.
`timescale 1ns / 1ps

module utf8sd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/utf8sd_back.sv */
// Back end: expands queued jobs into result beats through an output register.
`timescale 1ns / 1ps

module utf8sd_back #(
	parameter int OFFSET_WIDTH = 32,
	parameter int ENTRY_W      = utf8sd_pkg::KIND_W + utf8sd_pkg::CP_W + OFFSET_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  logic [ENTRY_W-1:0]    job,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_stall,
	output utf8sd_pkg::out_beat_t res_data
);

	logic [1:0]              kind;
	logic [20:0]             cp;
	logic [OFFSET_WIDTH-1:0] off;
	logic                    advance;
	logic                    pend_end_q, valid_q;
	utf8sd_pkg::out_beat_t   data_q, load;

	assign {kind, cp, off} = job;
	assign advance = !valid_q || !res_stall;
	assign pop     = advance && !pend_end_q && job_valid;

	always_comb begin
		load = '0;
		if (pend_end_q) begin
			// second beat of a character that closed its string
			load.status      = utf8sd_pkg::STATUS_END;
			load.string_done = 1'b1;
		end else begin
			case (kind)
				utf8sd_pkg::KIND_CHAR, utf8sd_pkg::KIND_CHAR_END: begin
					load.status     = utf8sd_pkg::STATUS_CHAR;
					load.code_point = cp;
				end
				utf8sd_pkg::KIND_END: begin
					load.status      = utf8sd_pkg::STATUS_END;
					load.string_done = 1'b1;
				end
				utf8sd_pkg::KIND_ERR: begin
					load.status       = utf8sd_pkg::STATUS_ERR;
					load.error_offset = 32'(off);
					load.string_done  = 1'b1;
				end
				default: load = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pend_end_q <= 1'b0;
		end else if (advance) begin
			if (pend_end_q) begin
				valid_q    <= 1'b1;
				pend_end_q <= 1'b0;
			end else begin
				valid_q    <= job_valid;
				pend_end_q <= job_valid && (kind == utf8sd_pkg::KIND_CHAR_END);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (pend_end_q || job_valid)) begin
			data_q <= load;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = data_q;

endmodule

/* rtl/core/utf8_strict_decoder.sv */
// Top level of the strict streaming UTF-8 decoder.
`timescale 1ns / 1ps

//  channel | direction | handshake               | payload
//  byte    | in        | byte_valid / byte_stall | in_beat_t  {data_byte, end_of_string}
//  res     | out       | res_valid / res_stall   | out_beat_t {status, code_point,
//          |           |                         |             error_offset, string_done}
//
// One byte is taken per cycle while the queue is not full; the front state machine
// settles each byte combinationally. A result passes through the queue, then the output
// register. A byte that completes a character and ends the string gives two beats, the
// character beat then the end beat; otherwise the back end drains one job per cycle
// unless res_stall holds the output register. byte_stall rises only when the four-entry
// queue is full. arst_n clears all control state; no clearing pass is needed.

module utf8_strict_decoder #(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  utf8sd_pkg::in_beat_t  byte_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output utf8sd_pkg::out_beat_t res_data
);

	localparam int ENTRY_W = utf8sd_pkg::KIND_W + utf8sd_pkg::CP_W + OFFSET_WIDTH;

	logic               accept, push, pop, full, not_empty;
	logic [ENTRY_W-1:0] wr_entry, rd_entry;

	// queue full is a registered count, so stall never looks at valid
	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	utf8sd_front #(
		.OFFSET_WIDTH (OFFSET_WIDTH),
		.ENTRY_W      (ENTRY_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.beat   (byte_data),
		.push   (push),
		.entry  (wr_entry)
	);

	utf8sd_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (utf8sd_pkg::QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (wr_entry),
		.pop       (pop),
		.rdata     (rd_entry),
		.full      (full),
		.not_empty (not_empty)
	);

	utf8sd_back #(
		.OFFSET_WIDTH (OFFSET_WIDTH),
		.ENTRY_W      (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (not_empty),
		.job       (rd_entry),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

/* rtl/core/utf8sd_checker.sv */
// Port-level checker for the UTF-8 decoder, bound to the top level.
`timescale 1ns / 1ps

module utf8sd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_stall,
	input utf8sd_pkg::in_beat_t  byte_data,
	input logic                  res_valid,
	input logic                  res_stall,
	input utf8sd_pkg::out_beat_t res_data
);

	// a stalled byte beat holds
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("byte beat changed while stalled");

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

	// character beats never close a string
	a_char_open: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status == utf8sd_pkg::STATUS_CHAR |-> !res_data.string_done)
		else $error("character beat marked string_done");

	// end and error beats close the string and carry no code point
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != utf8sd_pkg::STATUS_CHAR
		|-> res_data.string_done && res_data.code_point == '0)
		else $error("closing beat malformed");

	// offset only on error beats
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != utf8sd_pkg::STATUS_ERR |-> res_data.error_offset == '0)
		else $error("offset set on non-error beat");

endmodule

bind utf8_strict_decoder utf8sd_checker u_utf8sd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.byte_data  (byte_data),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_data   (res_data)
);
